FILE: rtl/core/sofsm_pkg.sv
// sofsm_pkg: shared codes, widths and constants for the static object pixel fsm
// used by every module in rtl/core; depends on nothing
package sofsm_pkg;

    localparam int unsigned INDEX_W = 18;
    localparam int unsigned MASK_W  = 8;
    localparam int unsigned CODE_W  = 2;
    localparam int unsigned CFG_W   = 16;

    // foreground marker in both mask bytes
    localparam logic [MASK_W-1:0] FG_BYTE = 8'hFF;

    // reset value of the dwell threshold register
    localparam logic [CFG_W-1:0] STABLE_RESET = 16'd450;

    // pixel state codes
    localparam logic [CODE_W-1:0] CODE_NONE = 2'd0;
    localparam logic [CODE_W-1:0] CODE_LONG = 2'd1;
    localparam logic [CODE_W-1:0] CODE_BOTH = 2'd3;

    // per-pixel result flags leaving the update logic
    typedef struct packed {
        logic candidate;
        logic stable;
    } pix_flags_t;

endpackage

FILE: rtl/core/sofsm_store.sv
// sofsm_store: per-pixel state memory with registered read, post-reset clear sweep
// and write-to-read forwarding; uses sofsm_pkg
module sofsm_store
    import sofsm_pkg::*;
#(
    parameter int unsigned DEPTH  = 262144,
    parameter int unsigned ADDR_W = 18,
    parameter int unsigned DATA_W = 20
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic              clr_busy
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_q_reg;
    logic [ADDR_W-1:0] rd_addr_reg;

    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    logic              wb_valid_reg;
    logic [ADDR_W-1:0] wb_addr_reg;
    logic [DATA_W-1:0] wb_data_reg;

    assign clr_addr_next = clr_addr_reg + ADDR_W'(1);
    assign clr_busy      = clr_busy_reg;

    // memory array, one write port and one read port
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg    <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // clear sweep and last-write tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            wb_valid_reg <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                if (clr_addr_reg == LAST_ADDR) begin
                    clr_busy_reg <= 1'b0;
                end else begin
                    clr_addr_reg <= clr_addr_next;
                end
            end
            if (wr_en && !clr_busy_reg) begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && !clr_busy_reg) begin
            wb_addr_reg <= wr_addr;
            wb_data_reg <= wr_data;
        end
    end

    // the newest write wins over a read that raced it
    assign rd_data = (wb_valid_reg && (wb_addr_reg == rd_addr_reg)) ? wb_data_reg : rd_q_reg;

endmodule

FILE: rtl/core/sofsm_update.sv
// sofsm_update: next-state logic for one pixel entry (code, flags, dwell counter)
// uses sofsm_pkg
module sofsm_update
    import sofsm_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic [CODE_W+COUNT_BITS+1:0] entry_in,
    input  logic [CODE_W-1:0]            now_code,
    input  logic [CFG_W-1:0]             threshold,
    output logic [CODE_W+COUNT_BITS+1:0] entry_out,
    output pix_flags_t                   flags
);

    localparam int unsigned CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [CODE_W-1:0]     prev_code;
    logic                  cand;
    logic                  stab;
    logic [COUNT_BITS-1:0] dwell;
    logic                  cand_next;
    logic                  stab_next;
    logic [COUNT_BITS-1:0] dwell_next;
    logic                  hold_long;

    assign prev_code = entry_in[CODE_W+COUNT_BITS+1 -: CODE_W];
    assign cand      = entry_in[COUNT_BITS+1];
    assign stab      = entry_in[COUNT_BITS];
    assign dwell     = entry_in[COUNT_BITS-1:0];
    assign hold_long = (now_code == CODE_LONG) && (prev_code == CODE_LONG);

    always_comb begin
        stab_next  = stab;
        cand_next  = 1'b0;
        dwell_next = '0;
        if (hold_long) begin
            // threshold test uses the count from before this frame
            if (CMP_W'(dwell) == CMP_W'(threshold)) begin
                stab_next = 1'b1;
            end
            cand_next  = cand;
            dwell_next = (cand && (dwell != COUNT_MAX)) ? dwell + COUNT_BITS'(1) : dwell;
        end
        // object just left the short-term mask
        if ((now_code == CODE_LONG) && (prev_code == CODE_BOTH)) begin
            cand_next = 1'b1;
        end
    end

    assign entry_out       = {now_code, cand_next, stab_next, dwell_next};
    assign flags.candidate = cand_next;
    assign flags.stable    = stab_next;

endmodule

FILE: rtl/core/static_object_pixel_fsm.sv
// static_object_pixel_fsm: top level, read-modify-write pipeline around the pixel store
// depends on sofsm_pkg, sofsm_store, sofsm_update
//
//  channel  | ports                                            | direction
//  ---------+--------------------------------------------------+----------
//  s_       | s_valid s_ready s_pixel_index s_short_value      | in
//           | s_long_value                                     |
//  m_       | m_valid m_ready m_out_index m_state_code         | out
//           | m_candidate_flag m_stable_flag                   |
//  cfg_     | cfg_we cfg_wdata (stable_frames)                 | in
//
// one pixel per clock sustained while m_ready stays high; each pixel passes the read stage
// (store read), then update and write-back into the output register
// after reset the store is swept to zero, one entry a cycle over min(FRAME_PIXELS, 2^18)
// entries, with s_ready low; cfg writes are taken during the sweep
// a stalled result holds in the output register; the read stage holds behind it and
// after the sweep, s_ready drops only when both are full and m_ready is low
module static_object_pixel_fsm
    import sofsm_pkg::*;
#(
    parameter int unsigned FRAME_PIXELS = 262144,
    parameter int unsigned COUNT_BITS   = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    // pixel input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [INDEX_W-1:0] s_pixel_index,
    input  logic [MASK_W-1:0]  s_short_value,
    input  logic [MASK_W-1:0]  s_long_value,
    // result output
    output logic               m_valid,
    input  logic               m_ready,
    output logic [INDEX_W-1:0] m_out_index,
    output logic [CODE_W-1:0]  m_state_code,
    output logic               m_candidate_flag,
    output logic               m_stable_flag
);

    // only indexes the port can carry need storage
    localparam int unsigned MEM_DEPTH =
        (FRAME_PIXELS < (2 ** INDEX_W)) ? FRAME_PIXELS : (2 ** INDEX_W);
    localparam int unsigned ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int unsigned DATA_W = CODE_W + 2 + COUNT_BITS;

    // threshold register
    logic [CFG_W-1:0] stable_frames_reg;

    // read stage: item whose entry is being fetched
    logic               s1_valid_reg;
    logic [INDEX_W-1:0] s1_index_reg;
    logic [CODE_W-1:0]  s1_code_reg;
    logic               s1_in_range_reg;

    // output register
    logic               m_valid_reg;
    logic [INDEX_W-1:0] m_index_reg;
    logic [CODE_W-1:0]  m_code_reg;
    logic               m_cand_reg;
    logic               m_stab_reg;

    logic               clr_busy;
    logic               advance;
    logic               in_xfer;
    logic [CODE_W-1:0]  now_code;
    logic               in_range;
    logic [DATA_W-1:0]  entry_rd;
    logic [DATA_W-1:0]  entry_wr;
    logic               commit_wr;
    pix_flags_t         flags;

    // the read stage moves on when the output register is free or being drained
    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = !clr_busy && (!s1_valid_reg || advance);
    assign in_xfer   = s_valid && s_ready;
    assign commit_wr = s1_valid_reg && advance && s1_in_range_reg;

    // code from the two mask bytes; a long-term miss always gives none
    always_comb begin
        if (s_long_value == FG_BYTE) begin
            now_code = (s_short_value == FG_BYTE) ? CODE_BOTH : CODE_LONG;
        end else begin
            now_code = CODE_NONE;
        end
    end

    assign in_range = (32'(s_pixel_index) < 32'(MEM_DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_frames_reg <= STABLE_RESET;
        end else if (cfg_we) begin
            stable_frames_reg <= cfg_wdata;
        end
    end

    sofsm_store #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (in_xfer && in_range),
        .rd_addr  (s_pixel_index[ADDR_W-1:0]),
        .rd_data  (entry_rd),
        .wr_en    (commit_wr),
        .wr_addr  (s1_index_reg[ADDR_W-1:0]),
        .wr_data  (entry_wr),
        .clr_busy (clr_busy)
    );

    sofsm_update #(
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .entry_in  (entry_rd),
        .now_code  (s1_code_reg),
        .threshold (stable_frames_reg),
        .entry_out (entry_wr),
        .flags     (flags)
    );

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (in_xfer) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_index_reg    <= s_pixel_index;
            s1_code_reg     <= now_code;
            s1_in_range_reg <= in_range;
        end
        if (advance && s1_valid_reg) begin
            m_index_reg <= s1_index_reg;
            m_code_reg  <= s1_code_reg;
            // pixels outside the frame report no flags
            m_cand_reg  <= s1_in_range_reg && flags.candidate;
            m_stab_reg  <= s1_in_range_reg && flags.stable;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_index      = m_index_reg;
    assign m_state_code     = m_code_reg;
    assign m_candidate_flag = m_cand_reg;
    assign m_stable_flag    = m_stab_reg;

endmodule

FILE: rtl/core/sofsm_checker.sv
// sofsm_checker: port-level assertions for static_object_pixel_fsm, bound to the top
// uses sofsm_pkg
module sofsm_checker
    import sofsm_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [INDEX_W-1:0] m_out_index,
    input logic [CODE_W-1:0]  m_state_code,
    input logic               m_candidate_flag,
    input logic               m_stable_flag
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_index) && $stable(m_state_code)
            && $stable(m_candidate_flag) && $stable(m_stable_flag))
        else $error("result changed while stalled");

    // a long-term miss can never leave a short-only code
    a_code_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_state_code == CODE_NONE) || (m_state_code == CODE_LONG)
            || (m_state_code == CODE_BOTH))
        else $error("illegal state code");

    // candidates exist only while the pixel is long-term only
    a_cand_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_candidate_flag |-> m_state_code == CODE_LONG)
        else $error("candidate flag with wrong code");

    // store sweep keeps input closed right after reset
    a_sweep_closed: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_ready)
        else $error("input open before store sweep");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind static_object_pixel_fsm sofsm_checker u_sofsm_checker (.*);
